>>> design/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and codes for the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

    // Opcodes carried by an input word.
    localparam logic [1:0] OP_POLL_PRESS  = 2'd0;
    localparam logic [1:0] OP_POLL_TOGGLE = 2'd1;
    localparam logic [1:0] OP_PRIME       = 2'd2;
    localparam logic [1:0] OP_RESET_PRESS = 2'd3;

    // Press kinds reported on the output.
    localparam logic [2:0] KIND_SINGLE = 3'd0;
    localparam logic [2:0] KIND_DOUBLE = 3'd1;
    localparam logic [2:0] KIND_LONG   = 3'd2;
    localparam logic [2:0] KIND_CLOSED = 3'd3;
    localparam logic [2:0] KIND_OPEN   = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SINGLE_TIME = 3'd0;
    localparam logic [2:0] CFG_LONG_TIME   = 3'd1;
    localparam logic [2:0] CFG_DOUBLE_TIME = 3'd2;
    localparam logic [2:0] CFG_TOGGLE_TIME = 3'd3;
    localparam logic [2:0] CFG_ACTIVE_LOW  = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_ms;
        logic        level;
    } in_word_t;

    typedef struct packed {
        logic       fired;
        logic [2:0] press_kind;
    } out_word_t;

    // Requests from a state machine to the shared registers in the top level.
    typedef struct packed {
        logic       fired;
        logic       kind_we;
        logic [2:0] kind;
        logic       alarm_we;
    } fsm_upd_t;

endpackage

>>> design/button_press_classifier_core.sv
// ----------------------------------------------------------------------------
// button_press_classifier_core
// Classifies a sampled pushbutton level into single, double and long presses
// and a debounced closed/open toggle.
//
// Each input word carries an opcode, the current time in milliseconds and the
// raw pin level, and produces exactly one output word holding the event flag
// and the current press kind. Opcode poll press runs the press machine, poll
// toggle runs the toggle machine, prime check moves a held press to primed,
// and reset press returns the press machine to idle. Alarm times are sums of
// the time and a configured delay, wrapping modulo 2^TIME_WIDTH, and an alarm
// has passed when the time is strictly greater, compared unsigned. The press
// and toggle machines share one alarm register. The block is a two-stage
// pipeline: an input register, then one pass of compare and add logic that
// updates the state and loads the output register. A word can be accepted in
// every cycle while the output side does not stall. Its output word is
// registered in the output register and held there until taken; throughput
// is one word per cycle when the output side does not stall. Configuration
// writes are always ready and should only be issued while no word is in
// flight.
// ----------------------------------------------------------------------------
module button_press_classifier_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bpc_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output bpc_pkg::out_word_t out_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    // Configuration registers.
    logic [15:0] single_time_reg;
    logic [15:0] long_time_reg;
    logic [15:0] double_time_reg;
    logic [15:0] toggle_time_reg;
    logic        active_low_reg;

    // Input stage.
    logic              s1_valid_reg;
    bpc_pkg::in_word_t s1_word_reg;

    // Output stage.
    logic               out_valid_reg;
    bpc_pkg::out_word_t out_word_reg;

    // Shared state.
    logic [TIME_WIDTH-1:0] single_alarm_reg, single_alarm_next;
    logic [2:0]            kind_reg, kind_next;

    logic                  advance;
    logic                  step;
    logic [TIME_WIDTH-1:0] t;
    logic                  pressed;
    bpc_pkg::fsm_upd_t     press_upd, toggle_upd;
    logic [TIME_WIDTH-1:0] press_alarm, toggle_alarm;

    assign cfg_ready = 1'b1;

    // The output register frees up when it is empty or being taken.
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Time is taken modulo 2^TIME_WIDTH; the polarity register decides which
    // level counts as pressed.
    assign t       = TIME_WIDTH'(s1_word_reg.now_ms);
    assign pressed = s1_word_reg.level ^ active_low_reg;

    bpc_press_fsm #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_press (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .op           (s1_word_reg.opcode),
        .t            (t),
        .pressed      (pressed),
        .single_time  (single_time_reg),
        .long_time    (long_time_reg),
        .double_time  (double_time_reg),
        .single_alarm (single_alarm_reg),
        .upd          (press_upd),
        .alarm_value  (press_alarm)
    );

    bpc_toggle_fsm #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_toggle (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .op           (s1_word_reg.opcode),
        .t            (t),
        .pressed      (pressed),
        .toggle_time  (toggle_time_reg),
        .single_alarm (single_alarm_reg),
        .upd          (toggle_upd),
        .alarm_value  (toggle_alarm)
    );

    // Only one machine runs per word, so at most one of them writes the shared
    // alarm and kind registers.
    always_comb
    begin
        single_alarm_next = single_alarm_reg;
        kind_next         = kind_reg;
        if (press_upd.alarm_we)
        begin
            single_alarm_next = press_alarm;
        end
        else if (toggle_upd.alarm_we)
        begin
            single_alarm_next = toggle_alarm;
        end
        if (press_upd.kind_we)
        begin
            kind_next = press_upd.kind;
        end
        else if (toggle_upd.kind_we)
        begin
            kind_next = toggle_upd.kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_time_reg <= 16'd5;
            long_time_reg   <= 16'd2000;
            double_time_reg <= 16'd200;
            toggle_time_reg <= 16'd5;
            active_low_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bpc_pkg::CFG_SINGLE_TIME: single_time_reg <= cfg_data;
                bpc_pkg::CFG_LONG_TIME:   long_time_reg   <= cfg_data;
                bpc_pkg::CFG_DOUBLE_TIME: double_time_reg <= cfg_data;
                bpc_pkg::CFG_TOGGLE_TIME: toggle_time_reg <= cfg_data;
                bpc_pkg::CFG_ACTIVE_LOW:  active_low_reg  <= cfg_data[0];
                default:                  active_low_reg  <= active_low_reg;
            endcase
        end
    end

    // Input stage: load a new word whenever the stage is empty or moving on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_word_reg <= in_word;
        end
    end

    // State update and output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            single_alarm_reg <= '0;
            kind_reg         <= bpc_pkg::KIND_OPEN;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (step)
            begin
                single_alarm_reg <= single_alarm_next;
                kind_reg         <= kind_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_word_reg.fired      <= press_upd.fired | toggle_upd.fired;
            out_word_reg.press_kind <= kind_next;
        end
    end

    // The two machines never act on the same word.
    a_one_machine: assert property (@(posedge clk) disable iff (!rst_n)
        !(press_upd.fired && toggle_upd.fired)) else $error("both machines fired");

    a_one_alarm_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(press_upd.alarm_we && toggle_upd.alarm_we)) else $error("alarm write clash");

    // Stalling the input only happens while a word waits in the input stage.
    a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg) else $error("input stalled with empty stage");

    // The reported kind is always a defined code.
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.press_kind <= bpc_pkg::KIND_OPEN))
        else $error("undefined press kind");

endmodule

>>> design/bpc_press_fsm.sv
// ----------------------------------------------------------------------------
// bpc_press_fsm
// Single, double and long press state machine with its own alarm registers.
// ----------------------------------------------------------------------------
module bpc_press_fsm #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [1:0]            op,
    input  logic [TIME_WIDTH-1:0] t,
    input  logic                  pressed,
    input  logic [15:0]           single_time,
    input  logic [15:0]           long_time,
    input  logic [15:0]           double_time,
    input  logic [TIME_WIDTH-1:0] single_alarm,
    output bpc_pkg::fsm_upd_t     upd,
    output logic [TIME_WIDTH-1:0] alarm_value
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_HELD   = 3'd1,
        ST_PRIMED = 3'd2,
        ST_LONG   = 3'd3,
        ST_SECOND = 3'd4,
        ST_DONE   = 3'd5
    } press_state_t;

    press_state_t          state_reg, state_next;
    logic                  pending_reg, pending_next;
    logic [TIME_WIDTH-1:0] double_alarm_reg, double_alarm_next;
    logic [TIME_WIDTH-1:0] long_alarm_reg, long_alarm_next;
    logic [16:0]           window_sum;
    logic                  past_single, past_double, past_long;

    assign window_sum  = {1'b0, single_time} + {1'b0, double_time};
    assign past_single = t > single_alarm;
    assign past_double = t > double_alarm_reg;
    assign past_long   = t > long_alarm_reg;
    assign alarm_value = t + TIME_WIDTH'(single_time);

    always_comb
    begin
        state_next        = state_reg;
        pending_next      = pending_reg;
        double_alarm_next = double_alarm_reg;
        long_alarm_next   = long_alarm_reg;
        upd               = '0;
        upd.kind          = bpc_pkg::KIND_SINGLE;
        case (op)
            bpc_pkg::OP_POLL_PRESS:
            begin
                case (state_reg)
                    ST_IDLE:
                    begin
                        if (pending_reg && past_double)
                        begin
                            pending_next = 1'b0;
                            upd.fired    = 1'b1;
                            upd.kind_we  = 1'b1;
                            upd.kind     = bpc_pkg::KIND_SINGLE;
                        end
                        else if (pressed)
                        begin
                            upd.alarm_we = 1'b1;
                            if (!pending_reg)
                            begin
                                state_next        = ST_HELD;
                                double_alarm_next = t + TIME_WIDTH'(window_sum);
                                long_alarm_next   = t + TIME_WIDTH'(long_time);
                            end
                            else
                            begin
                                state_next = ST_SECOND;
                            end
                        end
                    end
                    ST_HELD, ST_PRIMED:
                    begin
                        if (!pressed)
                        begin
                            state_next = ST_IDLE;
                            if (past_single)
                            begin
                                pending_next = 1'b1;
                            end
                        end
                        else if (past_long)
                        begin
                            long_alarm_next = t + TIME_WIDTH'(long_time);
                            state_next      = ST_LONG;
                            upd.fired       = 1'b1;
                            upd.kind_we     = 1'b1;
                            upd.kind        = bpc_pkg::KIND_LONG;
                        end
                    end
                    ST_LONG:
                    begin
                        if (!pressed)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (past_long)
                        begin
                            long_alarm_next = t + TIME_WIDTH'(long_time);
                            upd.fired       = 1'b1;
                            upd.kind_we     = 1'b1;
                            upd.kind        = bpc_pkg::KIND_LONG;
                        end
                    end
                    ST_SECOND:
                    begin
                        if (!pressed)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (past_single)
                        begin
                            state_next   = ST_DONE;
                            pending_next = 1'b0;
                            upd.fired    = 1'b1;
                            upd.kind_we  = 1'b1;
                            upd.kind     = bpc_pkg::KIND_DOUBLE;
                        end
                    end
                    ST_DONE:
                    begin
                        if (!pressed)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = state_reg;
                    end
                endcase
            end
            bpc_pkg::OP_PRIME:
            begin
                if (past_single && state_reg == ST_HELD)
                begin
                    state_next = ST_PRIMED;
                    upd.fired  = 1'b1;
                end
            end
            bpc_pkg::OP_RESET_PRESS:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pending_reg      <= 1'b0;
            double_alarm_reg <= '0;
            long_alarm_reg   <= '0;
        end
        else if (step)
        begin
            state_reg        <= state_next;
            pending_reg      <= pending_next;
            double_alarm_reg <= double_alarm_next;
            long_alarm_reg   <= long_alarm_next;
        end
    end

endmodule

>>> design/bpc_toggle_fsm.sv
// ----------------------------------------------------------------------------
// bpc_toggle_fsm
// Debounced closed/open toggle state machine.
// ----------------------------------------------------------------------------
module bpc_toggle_fsm #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [1:0]            op,
    input  logic [TIME_WIDTH-1:0] t,
    input  logic                  pressed,
    input  logic [15:0]           toggle_time,
    input  logic [TIME_WIDTH-1:0] single_alarm,
    output bpc_pkg::fsm_upd_t     upd,
    output logic [TIME_WIDTH-1:0] alarm_value
);

    typedef enum logic [1:0] {
        ST_OPEN    = 2'd0,
        ST_CLOSING = 2'd1,
        ST_CLOSED  = 2'd2
    } toggle_state_t;

    toggle_state_t state_reg, state_next;

    assign alarm_value = t + TIME_WIDTH'(toggle_time);

    always_comb
    begin
        state_next = state_reg;
        upd        = '0;
        upd.kind   = bpc_pkg::KIND_OPEN;
        if (op == bpc_pkg::OP_POLL_TOGGLE)
        begin
            case (state_reg)
                ST_OPEN:
                begin
                    if (pressed)
                    begin
                        upd.alarm_we = 1'b1;
                        state_next   = ST_CLOSING;
                    end
                end
                ST_CLOSING:
                begin
                    if (!pressed)
                    begin
                        state_next = ST_OPEN;
                    end
                    else if (t > single_alarm)
                    begin
                        state_next  = ST_CLOSED;
                        upd.fired   = 1'b1;
                        upd.kind_we = 1'b1;
                        upd.kind    = bpc_pkg::KIND_CLOSED;
                    end
                end
                ST_CLOSED:
                begin
                    if (!pressed)
                    begin
                        state_next  = ST_OPEN;
                        upd.fired   = 1'b1;
                        upd.kind_we = 1'b1;
                        upd.kind    = bpc_pkg::KIND_OPEN;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_OPEN;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

endmodule
